[hw/rtl/kss_pkg.sv]
// Package for the KMP substring search unit: word widths, codes and FSM states.
// Used by the channel interfaces, the top level and the checker.
`timescale 1ns / 1ps

package kss_pkg;

   localparam int DATA_W          = 8;
   localparam int STATUS_W        = 2;
   localparam int MATCH_POS_W     = 20;
   localparam int POS_EXT_W       = 32;
   localparam int MAX_PATTERN_DEF = 32;
   localparam int POS_BITS_DEF    = 20;

   localparam logic FUNC_PATTERN = 1'b0;
   localparam logic FUNC_TEXT    = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_MATCH     = 2'd0,
      STATUS_NO_MATCH  = 2'd1,
      STATUS_TRUNCATED = 2'd2
   } kss_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } kss_state_type;

endpackage

[hw/rtl/kss_stream_if.sv]
// Valid/ready channel interfaces for request and response words.
// Depends on kss_pkg for the field widths.
`timescale 1ns / 1ps

interface kss_req_if;
   import kss_pkg::*;

   logic              valid;
   logic              ready;
   logic              func;
   logic [DATA_W-1:0] data;
   logic              last;

   modport source (output valid, func, data, last, input ready);
   modport sink   (input valid, func, data, last, output ready);
endinterface

interface kss_rsp_if;
   import kss_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [MATCH_POS_W-1:0] match_pos;

   modport source (output valid, status, match_pos, input ready);
   modport sink   (input valid, status, match_pos, output ready);
endinterface

[hw/rtl/kmp_substring_search_unit.sv]
// KMP first-match substring search: pattern load with online failure table, text scan.
// Depends on kss_pkg and the kss_req_if / kss_rsp_if channel interfaces.
`timescale 1ns / 1ps

// One word is taken at a time; req.ready is low while a word is worked on. A word that
// needs no table walk (empty or full pattern store, search already done) goes from IDLE
// straight to COMMIT. Any other word walks the failure table through one shared compare
// stage fed by the pattern and failure memories, one step a cycle in SCAN, with one step
// more for each failure fallback for that byte (amortised to about one per text byte over
// a stream). A word that yields a result waits in COMMIT while the previous response is
// still not taken. Both memories start undefined and need no clearing after reset.
module kmp_substring_search_unit #(
   parameter int MAX_PATTERN = kss_pkg::MAX_PATTERN_DEF,
   parameter int POS_BITS    = kss_pkg::POS_BITS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   kss_req_if.sink   req,
   kss_rsp_if.source rsp
);
   import kss_pkg::*;

   localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
   localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   kss_state_type state_ff, state_in;

   logic                   func_ff, func_in;
   logic [DATA_W-1:0]      data_ff, data_in;
   logic                   last_ff, last_in;
   logic [LEN_BITS-1:0]    j_ff, j_in;

   logic [LEN_BITS-1:0]    pattern_length_ff, pattern_length_in;
   logic [IDX_BITS-1:0]    build_prefix_ff, build_prefix_in;
   logic [LEN_BITS-1:0]    matched_count_ff, matched_count_in;
   logic [POS_BITS-1:0]    text_position_ff, text_position_in;
   logic                   search_done_ff, search_done_in;
   logic                   truncated_ff, truncated_in;
   logic                   closed_ff, closed_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [MATCH_POS_W-1:0] rsp_pos_ff, rsp_pos_in;

   logic [DATA_W-1:0]      pattern_mem [MAX_PATTERN];
   logic [IDX_BITS-1:0]    failure_mem [MAX_PATTERN];
   logic [DATA_W-1:0]      p_q_ff;
   logic [IDX_BITS-1:0]    f_q_ff;

   logic                   accept;
   logic                   slot_free;
   logic                   commit_go;
   logic                   scan_eq;
   logic                   scan_fall;
   logic [LEN_BITS-1:0]    j0;
   logic [LEN_BITS-1:0]    eff_len;
   logic [LEN_BITS-1:0]    rd_j;
   logic [LEN_BITS-1:0]    rd_jm1;

   logic                   cm_emit;
   kss_status_type         cm_status;
   logic [POS_BITS-1:0]    cm_pos;
   logic                   cm_we;
   logic [IDX_BITS-1:0]    cm_waddr;
   logic [IDX_BITS-1:0]    cm_k;
   logic [LEN_BITS-1:0]    cm_length;
   logic [IDX_BITS-1:0]    cm_prefix;
   logic [LEN_BITS-1:0]    cm_matched;
   logic [POS_BITS-1:0]    cm_text_pos;
   logic                   cm_done;
   logic                   cm_trunc;
   logic                   cm_closed;
   logic [POS_BITS-1:0]    match_start;
   logic [POS_EXT_W-1:0]   pos_ext;

   assign accept    = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign scan_eq   = (data_ff == p_q_ff);
   assign scan_fall = (j_ff != '0) && !scan_eq;
   assign eff_len   = closed_ff ? '0 : pattern_length_ff;
   assign commit_go = (state_ff == ST_COMMIT) && (!cm_emit || slot_free);

   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.match_pos = rsp_pos_ff;

   always_comb begin
      if (req.func == FUNC_TEXT) begin
         j0 = (matched_count_ff >= pattern_length_ff) ? '0 : matched_count_ff;
      end else begin
         j0 = closed_ff ? '0 : LEN_BITS'(build_prefix_ff);
      end
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: rd_j = j0;
         ST_SCAN: rd_j = scan_fall ? LEN_BITS'(f_q_ff) : j_ff;
         default: rd_j = j_ff;
      endcase
      rd_jm1 = rd_j - LEN_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (commit_go && cm_we) begin
         pattern_mem[cm_waddr] <= data_ff;
      end
      p_q_ff <= pattern_mem[rd_j[IDX_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (commit_go && cm_we) begin
         failure_mem[cm_waddr] <= cm_k;
      end
      f_q_ff <= failure_mem[rd_jm1[IDX_BITS-1:0]];
   end

   // Final step of a word: table write, search bookkeeping and the result.
   always_comb begin
      match_start = text_position_ff + POS_BITS'(1) - POS_BITS'(pattern_length_ff);
      cm_emit     = 1'b0;
      cm_status   = STATUS_MATCH;
      cm_pos      = '0;
      cm_we       = 1'b0;
      cm_waddr    = pattern_length_ff[IDX_BITS-1:0];
      cm_k        = (pattern_length_ff == '0) ? '0 : j_ff[IDX_BITS-1:0];
      cm_length   = pattern_length_ff;
      cm_prefix   = build_prefix_ff;
      cm_matched  = matched_count_ff;
      cm_text_pos = text_position_ff;
      cm_done     = search_done_ff;
      cm_trunc    = truncated_ff;
      cm_closed   = closed_ff;
      if (func_ff == FUNC_PATTERN) begin
         if (pattern_length_ff >= LEN_BITS'(MAX_PATTERN)) begin
            cm_trunc = 1'b1;
         end else begin
            cm_we     = 1'b1;
            cm_prefix = cm_k;
            cm_length = pattern_length_ff + LEN_BITS'(1);
         end
         if (last_ff) begin
            cm_closed   = 1'b1;
            cm_matched  = '0;
            cm_text_pos = '0;
            cm_done     = 1'b0;
            if (cm_trunc) begin
               cm_emit   = 1'b1;
               cm_status = STATUS_TRUNCATED;
            end
         end
      end else begin
         if (!search_done_ff) begin
            if (pattern_length_ff == '0) begin
               cm_done = 1'b1;
               cm_emit = 1'b1;
               cm_pos  = text_position_ff;
            end else if (j_ff == pattern_length_ff) begin
               cm_done    = 1'b1;
               cm_emit    = 1'b1;
               cm_pos     = match_start;
               cm_matched = '0;
            end else begin
               cm_matched = j_ff;
            end
         end
         cm_text_pos = text_position_ff + POS_BITS'(1);
         if (last_ff) begin
            if (!cm_done) begin
               cm_emit   = 1'b1;
               cm_status = STATUS_NO_MATCH;
            end
            cm_matched  = '0;
            cm_text_pos = '0;
            cm_done     = 1'b0;
         end
      end
      pos_ext = POS_EXT_W'(cm_pos);
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            if (!accept) begin
               state_in = ST_IDLE;
            end else if (req.func == FUNC_TEXT) begin
               state_in = (search_done_ff || pattern_length_ff == '0) ? ST_COMMIT : ST_SCAN;
            end else begin
               state_in = (eff_len == '0 || eff_len >= LEN_BITS'(MAX_PATTERN)) ?
                          ST_COMMIT : ST_SCAN;
            end
         end
         ST_SCAN:   state_in = scan_fall ? ST_SCAN : ST_COMMIT;
         ST_COMMIT: state_in = commit_go ? ST_IDLE : ST_COMMIT;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      func_in           = func_ff;
      data_in           = data_ff;
      last_in           = last_ff;
      j_in              = j_ff;
      pattern_length_in = pattern_length_ff;
      build_prefix_in   = build_prefix_ff;
      matched_count_in  = matched_count_ff;
      text_position_in  = text_position_ff;
      search_done_in    = search_done_ff;
      truncated_in      = truncated_ff;
      closed_in         = closed_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp.ready;
      rsp_status_in     = rsp_status_ff;
      rsp_pos_in        = rsp_pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in = req.func;
               data_in = req.data;
               last_in = req.last;
               j_in    = j0;
               // a byte after a closed pattern starts a new one
               if (req.func == FUNC_PATTERN && closed_ff) begin
                  pattern_length_in = '0;
                  build_prefix_in   = '0;
                  truncated_in      = 1'b0;
                  closed_in         = 1'b0;
                  matched_count_in  = '0;
                  text_position_in  = '0;
                  search_done_in    = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            j_in = scan_fall ? LEN_BITS'(f_q_ff) : (j_ff + LEN_BITS'(scan_eq));
         end
         ST_COMMIT: begin
            if (commit_go) begin
               pattern_length_in = cm_length;
               build_prefix_in   = cm_prefix;
               matched_count_in  = cm_matched;
               text_position_in  = cm_text_pos;
               search_done_in    = cm_done;
               truncated_in      = cm_trunc;
               closed_in         = cm_closed;
               if (cm_emit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = cm_status;
                  rsp_pos_in    = pos_ext[MATCH_POS_W-1:0];
               end
            end
         end
         default: begin
            j_in = j_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         pattern_length_ff <= '0;
         build_prefix_ff   <= '0;
         matched_count_ff  <= '0;
         text_position_ff  <= '0;
         search_done_ff    <= 1'b0;
         truncated_ff      <= 1'b0;
         closed_ff         <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         pattern_length_ff <= pattern_length_in;
         build_prefix_ff   <= build_prefix_in;
         matched_count_ff  <= matched_count_in;
         text_position_ff  <= text_position_in;
         search_done_ff    <= search_done_in;
         truncated_ff      <= truncated_in;
         closed_ff         <= closed_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      data_ff       <= data_in;
      last_ff       <= last_in;
      j_ff          <= j_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

endmodule

[hw/rtl/kss_checker.sv]
// Port-level checks for kmp_substring_search_unit, attached by bind.
// Depends on kss_pkg for field widths and status codes.
`timescale 1ns / 1ps

module kss_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [kss_pkg::STATUS_W-1:0]    rsp_status,
   input logic [kss_pkg::MATCH_POS_W-1:0] rsp_match_pos
);
   import kss_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_MATCH |-> rsp_match_pos == '0)
      else $error("non-match response carries a position");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous word still in work");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response raised without a word in work");

endmodule

bind kmp_substring_search_unit kss_checker u_kss_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_status    (rsp.status),
   .rsp_match_pos (rsp.match_pos)
);

[verif/tb.sv]
// Self-checking bench for kmp_substring_search_unit: directed table with fixed or predicted
// results, then random pattern/text sets checked against a built-in KMP predictor.
// Depends on kss_pkg and the kss_req_if / kss_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb;
   import kss_pkg::*;

   localparam int ITEM_TARGET = 1550;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 64;
   localparam int N_DIRECTED  = 28;

   typedef struct packed {
      kss_status_type         status;
      logic [MATCH_POS_W-1:0] pos;
   } search_report_type;

   typedef struct {
      logic              fn;
      logic [DATA_W-1:0] data;
      logic              lst;
      bit                typed;
      bit                has_rsp;
      search_report_type rsp;
   } stim_row_type;

   localparam search_report_type NIL_REPORT = '{STATUS_MATCH, '0};

   logic clock;
   logic reset;

   kss_req_if req_bus ();
   kss_rsp_if rsp_bus ();

   kmp_substring_search_unit #(
      .MAX_PATTERN (MAX_PATTERN_DEF),
      .POS_BITS    (POS_BITS_DEF)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source)
   );

   // predictor state
   logic [DATA_W-1:0]       pat_bytes [MAX_PATTERN_DEF];
   int unsigned             fallback_tab [MAX_PATTERN_DEF];
   int unsigned             pat_count;
   int unsigned             load_prefix;
   int unsigned             scan_prefix;
   logic [POS_BITS_DEF-1:0] scan_pos;
   bit                      first_hit_seen;
   bit                      overflow_seen;
   bit                      pat_sealed;

   search_report_type pending_reports [$];
   int unsigned       mismatch_count;
   int unsigned       items_sent;
   int unsigned       cycle_count;
   bit                send_burst;
   bit                rsp_burst;
   int unsigned       rsp_hold;
   int unsigned       rsp_draw;
   search_report_type rsp_exp;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{FUNC_TEXT,    8'h78, 1'b0, 1'b1, 1'b1, '{STATUS_MATCH, 20'd0}},
      '{FUNC_TEXT,    8'h79, 1'b1, 1'b1, 1'b0, NIL_REPORT},
      '{FUNC_PATTERN, 8'h61, 1'b0, 1'b1, 1'b0, NIL_REPORT},
      '{FUNC_PATTERN, 8'h62, 1'b1, 1'b1, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'h78, 1'b0, 1'b0, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'h78, 1'b0, 1'b0, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'h61, 1'b0, 1'b0, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'h62, 1'b1, 1'b1, 1'b1, '{STATUS_MATCH, 20'd2}},
      '{FUNC_TEXT,    8'h61, 1'b1, 1'b1, 1'b1, '{STATUS_NO_MATCH, 20'd0}},
      '{FUNC_PATTERN, 8'hFF, 1'b0, 1'b1, 1'b0, NIL_REPORT},
      '{FUNC_PATTERN, 8'h00, 1'b1, 1'b1, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'h00, 1'b0, 1'b0, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'hFF, 1'b0, 1'b0, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'h00, 1'b1, 1'b1, 1'b1, '{STATUS_MATCH, 20'd1}},
      '{FUNC_PATTERN, 8'h63, 1'b0, 1'b1, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'h63, 1'b1, 1'b1, 1'b1, '{STATUS_MATCH, 20'd0}},
      '{FUNC_PATTERN, 8'h64, 1'b1, 1'b1, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'h63, 1'b0, 1'b0, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'h63, 1'b0, 1'b0, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'h64, 1'b1, 1'b0, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'hAA, 1'b1, 1'b1, 1'b1, '{STATUS_NO_MATCH, 20'd0}},
      '{FUNC_PATTERN, 8'h61, 1'b0, 1'b1, 1'b0, NIL_REPORT},
      '{FUNC_PATTERN, 8'h61, 1'b0, 1'b1, 1'b0, NIL_REPORT},
      '{FUNC_PATTERN, 8'h62, 1'b1, 1'b1, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'h61, 1'b0, 1'b0, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'h61, 1'b0, 1'b0, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'h61, 1'b0, 1'b0, 1'b0, NIL_REPORT},
      '{FUNC_TEXT,    8'h62, 1'b1, 1'b0, 1'b0, NIL_REPORT}
   };

   always #10 clock = ~clock;

   function automatic bit predict_kmp_report(input logic fn, input logic [DATA_W-1:0] c,
                                             input logic lst, output search_report_type rep);
      int unsigned k;
      bit hit;
      hit = 1'b0;
      rep = NIL_REPORT;
      if (fn == FUNC_PATTERN) begin
         if (pat_sealed) begin
            pat_count = 0;
            load_prefix = 0;
            overflow_seen = 1'b0;
            pat_sealed = 1'b0;
            scan_prefix = 0;
            scan_pos = '0;
            first_hit_seen = 1'b0;
         end
         if (pat_count >= MAX_PATTERN_DEF) begin
            overflow_seen = 1'b1;
         end else begin
            k = (pat_count == 0) ? 0 : load_prefix;
            if (pat_count != 0) begin
               while (k > 0 && c != pat_bytes[k]) k = fallback_tab[k-1];
               if (c == pat_bytes[k]) k++;
            end
            pat_bytes[pat_count] = c;
            fallback_tab[pat_count] = k;
            load_prefix = k;
            pat_count++;
         end
         if (lst) begin
            pat_sealed = 1'b1;
            scan_prefix = 0;
            scan_pos = '0;
            first_hit_seen = 1'b0;
            if (overflow_seen) begin
               rep = '{STATUS_TRUNCATED, '0};
               hit = 1'b1;
            end
         end
         return hit;
      end
      if (!first_hit_seen) begin
         if (pat_count == 0) begin
            first_hit_seen = 1'b1;
            rep = '{STATUS_MATCH, scan_pos};
            hit = 1'b1;
         end else begin
            k = (scan_prefix >= pat_count) ? 0 : scan_prefix;
            while (k > 0 && c != pat_bytes[k]) k = fallback_tab[k-1];
            if (c == pat_bytes[k]) k++;
            if (k == pat_count) begin
               first_hit_seen = 1'b1;
               rep = '{STATUS_MATCH, scan_pos + 1'b1 - POS_BITS_DEF'(pat_count)};
               hit = 1'b1;
               k = 0;
            end
            scan_prefix = k;
         end
      end
      scan_pos = scan_pos + 1'b1;
      if (lst) begin
         if (!first_hit_seen) begin
            rep = '{STATUS_NO_MATCH, '0};
            hit = 1'b1;
         end
         scan_prefix = 0;
         scan_pos = '0;
         first_hit_seen = 1'b0;
      end
      return hit;
   endfunction

   task automatic send_word(input logic fn, input logic [DATA_W-1:0] d, input logic lst,
                            output bit hit, output search_report_type rep);
      int unsigned gap;
      gap = send_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func  <= fn;
      req_bus.data  <= d;
      req_bus.last  <= lst;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      hit = predict_kmp_report(fn, d, lst, rep);
   endtask

   task automatic send_predicted(input logic fn, input logic [DATA_W-1:0] d, input logic lst);
      bit hit;
      search_report_type rep;
      send_word(fn, d, lst, hit, rep);
      if (hit) pending_reports = {pending_reports, rep};
   endtask

   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: status=%0d pos=%0d", rsp_bus.status,
                        rsp_bus.match_pos);
         end else begin
            rsp_exp = pending_reports.pop_front();
            if (rsp_bus.status !== rsp_exp.status || rsp_bus.match_pos !== rsp_exp.pos) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected status=%0d pos=%0d, got status=%0d pos=%0d",
                           rsp_exp.status, rsp_exp.pos, rsp_bus.status, rsp_bus.match_pos);
            end
         end
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         rsp_draw = rsp_burst ? 0 : $urandom_range(0, 10);
         rsp_bus.ready <= (rsp_draw == 0);
         rsp_hold <= rsp_draw;
      end else if (!rsp_bus.ready) begin
         if (rsp_hold <= 1) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_hold <= rsp_hold - 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      bit                hit;
      search_report_type rep;
      logic [DATA_W-1:0] sym_base;
      int unsigned       sym_span;
      int unsigned       plen;
      int unsigned       tlen;
      int unsigned       off;
      int unsigned       set_no;
      logic [DATA_W-1:0] cur_pattern [$];
      logic [DATA_W-1:0] text_buf [$];

      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func  = FUNC_PATTERN;
      req_bus.data  = '0;
      req_bus.last  = 1'b0;
      pat_count = 0;
      load_prefix = 0;
      scan_prefix = 0;
      scan_pos = '0;
      first_hit_seen = 1'b0;
      overflow_seen = 1'b0;
      pat_sealed = 1'b0;
      items_sent = 0;
      send_burst = 1'b0;
      sym_base = '0;
      sym_span = 1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].fn, directed_rows[i].data, directed_rows[i].lst, hit, rep);
         if (directed_rows[i].typed) begin
            if (directed_rows[i].has_rsp)
               pending_reports = {pending_reports, directed_rows[i].rsp};
         end else if (hit) begin
            pending_reports = {pending_reports, rep};
         end
      end
      hold_until_drained();

      set_no = 0;
      while (items_sent < ITEM_TARGET) begin
         send_burst = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 14) == 0) hold_until_drained();
         if (set_no == 0 || $urandom_range(0, 7) != 0) begin
            sym_base = DATA_W'($urandom_range(0, 255));
            sym_span = $urandom_range(1, 3);
            if (set_no == 0 || $urandom_range(0, 19) == 0) plen = $urandom_range(33, 40);
            else if ($urandom_range(0, 5) == 0) plen = $urandom_range(6, 32);
            else plen = $urandom_range(1, 5);
            cur_pattern.delete();
            repeat (plen)
               cur_pattern = {cur_pattern,
                              DATA_W'(sym_base + $urandom_range(0, sym_span - 1))};
            for (int i = 0; i < plen; i++) begin
               // search between pattern bytes (before the first byte, on the previous pattern)
               if ($urandom_range(0, 15) == 0)
                  send_predicted(FUNC_TEXT, DATA_W'(sym_base + $urandom_range(0, sym_span - 1)),
                                 1'($urandom_range(0, 1)));
               send_predicted(FUNC_PATTERN, cur_pattern[i], i == plen - 1);
            end
         end
         repeat ($urandom_range(1, 3)) begin
            tlen = $urandom_range(1, 25) + ((cur_pattern.size() > 5) ? cur_pattern.size() : 0);
            text_buf.delete();
            repeat (tlen)
               text_buf = {text_buf, DATA_W'(sym_base + $urandom_range(0, sym_span - 1))};
            if ($urandom_range(0, 1) == 1 && cur_pattern.size() <= tlen) begin
               off = $urandom_range(0, tlen - cur_pattern.size());
               foreach (cur_pattern[j]) text_buf[off + j] = cur_pattern[j];
            end
            for (int i = 0; i < tlen; i++)
               send_predicted(FUNC_TEXT, text_buf[i], i == tlen - 1);
         end
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 6))
               send_predicted(1'($urandom_range(0, 1)), DATA_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
         set_no++;
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
